[design/gtpag_pkg.sv]
// ----------------------------------------------------------------------------
// gtpag_pkg
// Shared widths, register codes and the configuration bundle of the tile
// page address generator.
// ----------------------------------------------------------------------------
package gtpag_pkg;

  // Rows of one group and the widths of the walk and page fields.
  localparam int unsigned ROWS       = 32;
  localparam int unsigned ROW_W      = 5;
  localparam int unsigned GRP_W      = 24;
  localparam int unsigned PAGE_W     = 32;
  localparam int unsigned DIVS_W     = 20;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VALUE_OFFSET     = 3'd0,
    REG_GATE_OFFSET      = 3'd1,
    REG_ROW_TILE_OFFSET  = 3'd2,
    REG_COL_TILES        = 3'd3,
    REG_LOGICAL_ROWS     = 3'd4,
    REG_SLICE_CHAN_TILES = 3'd5,
    REG_WIDE_CHAN_TILES  = 3'd6
  } cfg_reg_e;

  // Current register contents, handed from the register file to the core.
  typedef struct packed {
    logic [9:0]  value_offset;
    logic [9:0]  gate_offset;
    logic [9:0]  row_tile_offset;
    logic [10:0] col_tiles;
    logic [15:0] logical_rows;
    logic [8:0]  slice_chan_tiles;
    logic [10:0] wide_chan_tiles;
  } cfg_t;

  // Register values after reset.
  localparam logic [10:0] COL_TILES_RST        = 11'd1;
  localparam logic [15:0] LOGICAL_ROWS_RST     = 16'd32;
  localparam logic [8:0]  SLICE_CHAN_TILES_RST = 9'd1;
  localparam logic [10:0] WIDE_CHAN_TILES_RST  = 11'd4;

endpackage

[design/gtpag_in_if.sv]
// ----------------------------------------------------------------------------
// gtpag_in_if
// Work group request channel: start flag and the walk settings.
// ----------------------------------------------------------------------------
interface gtpag_in_if;
  import gtpag_pkg::*;

  logic             valid;
  logic             ready;
  logic             start_req;
  logic [GRP_W-1:0] first_group_index;
  logic [GRP_W-1:0] walk_stride;
  logic [GRP_W-1:0] wrap_high;
  logic [GRP_W-1:0] wrap_low;

  modport source (
    output valid, start_req, first_group_index, walk_stride, wrap_high, wrap_low,
    input  ready
  );
  modport sink (
    input  valid, start_req, first_group_index, walk_stride, wrap_high, wrap_low,
    output ready
  );
endinterface

[design/gtpag_out_if.sv]
// ----------------------------------------------------------------------------
// gtpag_out_if
// Page pair result channel: one transfer per row of the group.
// ----------------------------------------------------------------------------
interface gtpag_out_if;
  import gtpag_pkg::*;

  logic              valid;
  logic              ready;
  logic [PAGE_W-1:0] value_page;
  logic [PAGE_W-1:0] gate_page;
  logic [ROW_W-1:0]  row_in_tile;
  logic              is_padding;
  logic              last;

  modport source (
    output valid, value_page, gate_page, row_in_tile, is_padding, last,
    input  ready
  );
  modport sink (
    input  valid, value_page, gate_page, row_in_tile, is_padding, last,
    output ready
  );
endinterface

[design/gtpag_cfg_if.sv]
// ----------------------------------------------------------------------------
// gtpag_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface gtpag_cfg_if;
  import gtpag_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[design/gtpag_cfg_regs.sv]
// ----------------------------------------------------------------------------
// gtpag_cfg_regs
// Configuration register file. Every write transfer is taken at once; a write
// to an index past the register list is dropped.
// ----------------------------------------------------------------------------
module gtpag_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  gtpag_cfg_if.sink         cfg_i,
  output gtpag_pkg::cfg_t   cfg_o
);
  import gtpag_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  // Each register keeps the low bits of the written data.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_VALUE_OFFSET:     cfg_d.value_offset     = cfg_i.data[9:0];
        REG_GATE_OFFSET:      cfg_d.gate_offset      = cfg_i.data[9:0];
        REG_ROW_TILE_OFFSET:  cfg_d.row_tile_offset  = cfg_i.data[9:0];
        REG_COL_TILES:        cfg_d.col_tiles        = cfg_i.data[10:0];
        REG_LOGICAL_ROWS:     cfg_d.logical_rows     = cfg_i.data[15:0];
        REG_SLICE_CHAN_TILES: cfg_d.slice_chan_tiles = cfg_i.data[8:0];
        REG_WIDE_CHAN_TILES:  cfg_d.wide_chan_tiles  = cfg_i.data[10:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.value_offset     <= '0;
      cfg_q.gate_offset      <= '0;
      cfg_q.row_tile_offset  <= '0;
      cfg_q.col_tiles        <= COL_TILES_RST;
      cfg_q.logical_rows     <= LOGICAL_ROWS_RST;
      cfg_q.slice_chan_tiles <= SLICE_CHAN_TILES_RST;
      cfg_q.wide_chan_tiles  <= WIDE_CHAN_TILES_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[design/gtpag_div.sv]
// ----------------------------------------------------------------------------
// gtpag_div
// Restoring radix-2 divider, one quotient bit per cycle. A start pulse loads
// the operands; done pulses once the quotient and remainder are valid. The
// divisor must be nonzero.
// ----------------------------------------------------------------------------
module gtpag_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [gtpag_pkg::GRP_W-1:0]  dividend_i,
  input  logic [gtpag_pkg::DIVS_W-1:0] divisor_i,
  output logic                         done_o,
  output logic [gtpag_pkg::GRP_W-1:0]  quotient_o,
  output logic [gtpag_pkg::DIVS_W-1:0] remainder_o
);
  import gtpag_pkg::*;

  localparam int unsigned CNT_W = $clog2(GRP_W);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [GRP_W-1:0]  quo_q;
  logic [DIVS_W-1:0] rem_q;
  logic [DIVS_W-1:0] div_q;
  logic [DIVS_W:0]   trial;
  logic              take;
  logic [DIVS_W-1:0] rem_d;

  // One shift-and-subtract step.
  always_comb begin
    trial = {rem_q, quo_q[GRP_W-1]};
    take  = trial >= {1'b0, div_q};
    rem_d = take ? DIVS_W'(trial - {1'b0, div_q}) : trial[DIVS_W-1:0];
  end

  // Sequencing of the steps.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(GRP_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand and result registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[GRP_W-2:0], take};
      rem_q <= rem_d;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

  // The remainder is reduced below the divisor when done.
  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> rem_q < div_q)
    else $error("divider remainder not below divisor");

  // A start always begins a run, with the divider busy and not yet done.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q && !done_q)
    else $error("divider did not start");

  // Done is only reported once the steps have stopped.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider reported done while still busy");

endmodule

[design/gated_tile_page_address_generator_core.sv]
// ----------------------------------------------------------------------------
// gated_tile_page_address_generator_core
// Tile page index generator for a gated permute read.
// ----------------------------------------------------------------------------
// Usage: each transfer on in_i processes one work group. With start_req set
// it first loads the group index, stride and wrap bounds; otherwise it goes
// on from the stored walk. The group is split by two divisions on a shared
// radix-2 divider into row tile, column tile and channel block, then a shared
// multiplier forms the first page, the padding page and the row stride.
// out_o then carries 32 page pairs, one per row, with last on row 31. Rows
// past the logical length carry the row-0 pages of the tile column and are
// flagged as padding. Configuration writes on cfg_i are taken every cycle
// and belong between groups.
// Timing: in_i is ready only while idle. A group runs the setup states PERIT,
// DIV1, DIV2, MROW, MFIRST, MPAD and MSTRIDE (the two 24-step divisions
// dominate), then emits its 32 results in EMIT. A stall on out_o
// holds the output register and pauses the row walk. The last result may
// still wait in the output register while the next group is accepted.
// Reset clears the walk to zero and the registers to their reset values.
// ----------------------------------------------------------------------------
module gated_tile_page_address_generator_core #(
  parameter int unsigned CHAN_BLOCK = 1
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  gtpag_in_if.sink   in_i,
  gtpag_out_if.source out_o,
  gtpag_cfg_if.sink  cfg_i
);
  import gtpag_pkg::*;

  // Width of the channel tile offset of the block inside the slice.
  localparam int unsigned CT_W = 9 + $clog2(CHAN_BLOCK);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_PERIT   = 9'b000000010,
    S_DIV1    = 9'b000000100,
    S_DIV2    = 9'b000001000,
    S_MROW    = 9'b000010000,
    S_MFIRST  = 9'b000100000,
    S_MPAD    = 9'b001000000,
    S_MSTRIDE = 9'b010000000,
    S_EMIT    = 9'b100000000
  } state_e;

  cfg_t   cfg;
  state_e state_q, state_d;

  // Walk state.
  logic [GRP_W-1:0] cur_group_q, stride_q, wrap_high_q, wrap_low_q;
  logic [GRP_W-1:0] group_adv;

  // Split of the group and derived page values.
  logic [GRP_W-1:0]  it_q;
  logic [DIVS_W-1:0] jt_q;
  logic [8:0]        rem2_q;
  logic [5:0]        live_rows_q;
  logic [PAGE_W-1:0] prod_q, acc_q, row0_page_q, row_step_q;
  logic [ROW_W-1:0]  row_q;

  // Output register.
  logic              out_valid_q;
  logic [PAGE_W-1:0] value_page_q, gate_page_q;
  logic [ROW_W-1:0]  row_out_q;
  logic              pad_out_q, last_out_q;

  // Divider hookup.
  logic              div_start, div_done;
  logic [GRP_W-1:0]  div_dividend, div_quo;
  logic [DIVS_W-1:0] div_divisor, div_rem;

  // Shared multiplier.
  logic [PAGE_W-1:0]        mul_a;
  logic [10:0]              mul_b;
  logic [PAGE_W+10:0]       mul_full;

  logic [8:0]        blocks_raw, blocks;
  logic [DIVS_W-1:0] per_it;
  logic [CT_W-1:0]   ct0;
  logic [29:0]       row_abs;
  logic [30:0]       row_end;
  logic [30:0]       lrows_ext;
  logic [5:0]        live_rows_d;
  logic              in_xfer, load, pad_row;
  logic [PAGE_W-1:0] base;

  gtpag_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  gtpag_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;

  // Block count per column tile, with a zero count taken as one.
  assign blocks_raw = 9'(cfg.slice_chan_tiles / CHAN_BLOCK);
  assign blocks     = (blocks_raw == '0) ? 9'd1 : blocks_raw;

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_PERIT: begin
        mul_a = PAGE_W'(cfg.col_tiles);
        mul_b = {2'b00, blocks};
      end
      S_MROW: begin
        mul_a = PAGE_W'({it_q, 5'b00000});
        mul_b = cfg.col_tiles;
      end
      S_MFIRST: begin
        mul_a = prod_q + PAGE_W'(jt_q);
        mul_b = cfg.wide_chan_tiles;
      end
      S_MPAD: begin
        mul_a = PAGE_W'(jt_q);
        mul_b = cfg.wide_chan_tiles;
      end
      S_MSTRIDE: begin
        mul_a = PAGE_W'(cfg.col_tiles);
        mul_b = cfg.wide_chan_tiles;
      end
      default: ;
    endcase
  end

  assign mul_full = {11'b0, mul_a} * {{PAGE_W{1'b0}}, mul_b};

  // Tiles per row tile, with a zero product taken as one.
  assign per_it = (mul_full[DIVS_W-1:0] == '0) ? DIVS_W'(1) : mul_full[DIVS_W-1:0];

  // The first division splits off the row tile, the second the column tile.
  always_comb begin
    div_start    = 1'b0;
    div_dividend = cur_group_q;
    div_divisor  = per_it;
    if (state_q == S_PERIT) begin
      div_start = 1'b1;
    end else if (state_q == S_DIV1 && div_done) begin
      div_start    = 1'b1;
      div_dividend = GRP_W'(div_rem);
      div_divisor  = DIVS_W'(blocks);
    end
  end

  // Next group index of the walk.
  always_comb begin
    group_adv = cur_group_q + stride_q;
    if (group_adv == wrap_high_q) begin
      group_adv = wrap_low_q;
    end
  end

  // Valid row count of the row tile, capped at 32 and floored at zero.
  always_comb begin
    row_abs   = {GRP_W'(it_q) + GRP_W'(cfg.row_tile_offset) + 25'd0, 5'b00000};
    row_end   = {1'b0, row_abs} + 31'(ROWS);
    lrows_ext = 31'(cfg.logical_rows);
    if (row_end <= lrows_ext) begin
      live_rows_d = 6'(ROWS);
    end else if (lrows_ext > {1'b0, row_abs}) begin
      live_rows_d = 6'(lrows_ext - {1'b0, row_abs});
    end else begin
      live_rows_d = '0;
    end
  end

  // Page of the current row.
  assign ct0     = CT_W'(rem2_q * CHAN_BLOCK);
  assign pad_row = {1'b0, row_q} >= live_rows_q;
  assign base    = pad_row ? row0_page_q : acc_q;
  assign load    = (state_q == S_EMIT) && (!out_valid_q || out_o.ready);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:    if (in_xfer) state_d = S_PERIT;
      S_PERIT:   state_d = S_DIV1;
      S_DIV1:    if (div_done) state_d = S_DIV2;
      S_DIV2:    if (div_done) state_d = S_MROW;
      S_MROW:    state_d = S_MFIRST;
      S_MFIRST:  state_d = S_MPAD;
      S_MPAD:    state_d = S_MSTRIDE;
      S_MSTRIDE: state_d = S_EMIT;
      S_EMIT:    if (load && row_q == ROW_W'(ROWS - 1)) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // Control state and walk registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_group_q <= '0;
      stride_q    <= '0;
      wrap_high_q <= '0;
      wrap_low_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_xfer && in_i.start_req) begin
        cur_group_q <= in_i.first_group_index;
        stride_q    <= in_i.walk_stride;
        wrap_high_q <= in_i.wrap_high;
        wrap_low_q  <= in_i.wrap_low;
      end else if (state_q == S_PERIT) begin
        cur_group_q <= group_adv;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (state_q == S_DIV1 && div_done) begin
      it_q <= div_quo;
    end
    if (state_q == S_DIV2 && div_done) begin
      jt_q   <= div_quo[DIVS_W-1:0];
      rem2_q <= div_rem[8:0];
    end
    case (state_q)
      S_MROW: begin
        prod_q      <= mul_full[PAGE_W-1:0];
        live_rows_q <= live_rows_d;
      end
      S_MFIRST:  acc_q       <= mul_full[PAGE_W-1:0];
      S_MPAD:    row0_page_q <= mul_full[PAGE_W-1:0];
      S_MSTRIDE: begin
        row_step_q <= mul_full[PAGE_W-1:0];
        row_q      <= '0;
      end
      S_EMIT: begin
        if (load) begin
          acc_q <= acc_q + row_step_q;
          row_q <= row_q + 1'b1;
        end
      end
      default: ;
    endcase
    if (load) begin
      value_page_q <= base + PAGE_W'(cfg.value_offset) + PAGE_W'(ct0);
      gate_page_q  <= base + PAGE_W'(cfg.gate_offset) + PAGE_W'(ct0);
      row_out_q    <= row_q;
      pad_out_q    <= pad_row;
      last_out_q   <= (row_q == ROW_W'(ROWS - 1));
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.value_page  = value_page_q;
  assign out_o.gate_page   = gate_page_q;
  assign out_o.row_in_tile = row_out_q;
  assign out_o.is_padding  = pad_out_q;
  assign out_o.last        = last_out_q;

  // The divider reports only while the sequencer waits for it.
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV1 || state_q == S_DIV2))
    else $error("divider finished outside a division state");

  // Loading row 31 ends the group and presents a result marked last.
  a_last_row_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && row_q == ROW_W'(ROWS - 1)) |=>
      (state_q == S_IDLE && out_valid_q && last_out_q))
    else $error("group did not end on its last row");

  // An accepted group blocks further requests until it is done.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == S_PERIT && !in_i.ready))
    else $error("request accepted while busy");

endmodule

[tb/tb_gated_tile_page_address_generator_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gated_tile_page_address_generator_core
// Self-checking bench for the gated tile page address generator. Work group
// requests go in over the request channel. An in-bench scoreboard keeps its
// own copy of the walk and the register file, works out the 32 page pairs of
// each accepted group, and compares every returned pair field by field. A
// directed part covers register extremes, wrapping and short tails. Random
// phases with random register settings follow, built mostly from start
// requests followed by continued walks. Both channels stall at random.
// ----------------------------------------------------------------------------
module tb_gated_tile_page_address_generator_core;
  import gtpag_pkg::*;

  localparam int unsigned CHAN_BLOCK   = 1;
  localparam int          NUM_REGS     = 7;
  localparam int          ITEM_TARGET  = 400;
  localparam int          PHASE_ITEMS  = 35;
  // A group has its setup states to pass before its first result, so a long
  // quiet stretch means the block has hung.
  localparam int          QUIET_LIMIT  = 2000;
  localparam int          DRAIN_CYCLES = 100;

  typedef logic [CFG_DATA_W-1:0] reg_set_t [NUM_REGS];

  typedef struct {
    logic             start_req;
    logic [GRP_W-1:0] first_group_index;
    logic [GRP_W-1:0] walk_stride;
    logic [GRP_W-1:0] wrap_high;
    logic [GRP_W-1:0] wrap_low;
  } group_req_t;

  typedef struct packed {
    logic [PAGE_W-1:0] value_page;
    logic [PAGE_W-1:0] gate_page;
    logic [ROW_W-1:0]  row_in_tile;
    logic              is_padding;
    logic              last;
  } page_pair_t;

  // Scoreboard: tracks the walk and registers, expands each group into its
  // page pairs and checks returned pairs in order.
  class page_pair_checker;
    cfg_t             regs;
    logic [GRP_W-1:0] walk_group;
    logic [GRP_W-1:0] walk_stride;
    logic [GRP_W-1:0] walk_hi;
    logic [GRP_W-1:0] walk_lo;
    page_pair_t       expected_pairs[$];
    int               errors;
    int               checked;

    function new();
      regs                  = '0;
      regs.col_tiles        = COL_TILES_RST;
      regs.logical_rows     = LOGICAL_ROWS_RST;
      regs.slice_chan_tiles = SLICE_CHAN_TILES_RST;
      regs.wide_chan_tiles  = WIDE_CHAN_TILES_RST;
      walk_group            = '0;
      walk_stride           = '0;
      walk_hi               = '0;
      walk_lo               = '0;
      errors                = 0;
      checked               = 0;
    endfunction

    // Registers keep only as many bits as they are wide.
    function void write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_VALUE_OFFSET:     regs.value_offset     = data[9:0];
        REG_GATE_OFFSET:      regs.gate_offset      = data[9:0];
        REG_ROW_TILE_OFFSET:  regs.row_tile_offset  = data[9:0];
        REG_COL_TILES:        regs.col_tiles        = data[10:0];
        REG_LOGICAL_ROWS:     regs.logical_rows     = data[15:0];
        REG_SLICE_CHAN_TILES: regs.slice_chan_tiles = data[8:0];
        REG_WIDE_CHAN_TILES:  regs.wide_chan_tiles  = data[10:0];
        default: ;
      endcase
    endfunction

    // Channel blocks per column tile; a zero count is taken as one.
    function longint unsigned blocks_per_col();
      longint unsigned b;
      b = regs.slice_chan_tiles / CHAN_BLOCK;
      return (b == 0) ? 1 : b;
    endfunction

    // Groups per row tile; a zero product is taken as one.
    function longint unsigned groups_per_row_tile();
      longint unsigned p;
      p = regs.col_tiles * blocks_per_col();
      return (p == 0) ? 1 : p;
    endfunction

    // Group index that lands on an interesting row tile most of the time.
    function logic [GRP_W-1:0] pick_group();
      longint unsigned per_it;
      longint unsigned tgt;
      logic [GRP_W-1:0] grp;
      per_it = groups_per_row_tile();
      case ($urandom_range(0, 3))
        0: grp = GRP_W'($urandom);
        1: begin
          // Around the row tile where the logical length ends.
          tgt = regs.logical_rows >> 5;
          tgt = (tgt > regs.row_tile_offset) ? tgt - regs.row_tile_offset : 0;
          tgt = (tgt > 0) ? tgt - 1 + $urandom_range(0, 2) : $urandom_range(0, 1);
          grp = GRP_W'(tgt * per_it + $urandom_range(0, 32'(per_it - 1)));
        end
        default: begin
          tgt = $urandom_range(0, 1100);
          grp = GRP_W'(tgt * per_it + $urandom_range(0, 32'(per_it - 1)));
        end
      endcase
      return grp;
    endfunction

    // Expand one accepted request into its 32 page pairs and step the walk.
    function void note_group(group_req_t req);
      longint unsigned blocks, per_it, it, rem, jt, ct0;
      longint unsigned row_abs, live_rows, lrows, col, wide;
      longint unsigned row_step, start_page, row0_page, base;
      page_pair_t      pair;
      if (req.start_req) begin
        walk_group  = req.first_group_index;
        walk_stride = req.walk_stride;
        walk_hi     = req.wrap_high;
        walk_lo     = req.wrap_low;
      end
      blocks = blocks_per_col();
      per_it = groups_per_row_tile();
      col    = regs.col_tiles;
      wide   = regs.wide_chan_tiles;
      lrows  = regs.logical_rows;

      // Split the group: row tile, then column tile, block fastest.
      it  = walk_group / per_it;
      rem = walk_group - it * per_it;
      jt  = rem / blocks;
      ct0 = (rem - jt * blocks) * CHAN_BLOCK;

      // Rows still inside the logical length, capped at one group.
      row_abs = (it + regs.row_tile_offset) * ROWS;
      if (row_abs + ROWS <= lrows) live_rows = ROWS;
      else if (lrows > row_abs)    live_rows = lrows - row_abs;
      else                         live_rows = 0;

      row_step   = col * wide;
      start_page = (it * ROWS * col + jt) * wide;
      row0_page  = jt * wide;

      for (int unsigned r = 0; r < ROWS; r++) begin
        pair.is_padding  = (r >= live_rows);
        base             = pair.is_padding ? row0_page : start_page + r * row_step;
        pair.value_page  = PAGE_W'(base + regs.value_offset + ct0);
        pair.gate_page   = PAGE_W'(base + regs.gate_offset + ct0);
        pair.row_in_tile = ROW_W'(r);
        pair.last        = (r == ROWS - 1);
        expected_pairs.push_back(pair);
      end

      // Advance by the stride, wrapping on the wrap-high index.
      walk_group = walk_group + walk_stride;
      if (walk_group == walk_hi) walk_group = walk_lo;
    endfunction

    function void check_pair(page_pair_t got);
      page_pair_t want;
      if (expected_pairs.size() == 0) begin
        $error("unexpected page pair: value_page %0h gate_page %0h row %0d",
               got.value_page, got.gate_page, got.row_in_tile);
        errors++;
        return;
      end
      want = expected_pairs.pop_front();
      checked++;
      if (got.value_page !== want.value_page) begin
        $error("value_page: expected %0h, actual %0h", want.value_page, got.value_page);
        errors++;
      end
      if (got.gate_page !== want.gate_page) begin
        $error("gate_page: expected %0h, actual %0h", want.gate_page, got.gate_page);
        errors++;
      end
      if (got.row_in_tile !== want.row_in_tile) begin
        $error("row_in_tile: expected %0d, actual %0d", want.row_in_tile, got.row_in_tile);
        errors++;
      end
      if (got.is_padding !== want.is_padding) begin
        $error("is_padding: expected %0b, actual %0b", want.is_padding, got.is_padding);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, actual %0b", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  gtpag_in_if  in_if ();
  gtpag_out_if out_if ();
  gtpag_cfg_if cfg_if ();

  gated_tile_page_address_generator_core #(
    .CHAN_BLOCK(CHAN_BLOCK)
  ) uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  page_pair_checker sb;
  bit               steady;
  int               groups_sent;
  int               phases;
  int               quiet_cycles = 0;

  // 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Gap before each transfer; none at all in steady phases.
  function automatic int draw_gap();
    return steady ? 0 : $urandom_range(0, 4);
  endfunction

  // Continue request: the walk fields carry noise that must be ignored.
  function automatic group_req_t follow_on_req();
    group_req_t req;
    req.start_req         = 1'b0;
    req.first_group_index = GRP_W'($urandom);
    req.walk_stride       = GRP_W'($urandom);
    req.wrap_high         = GRP_W'($urandom);
    req.wrap_low          = GRP_W'($urandom);
    return req;
  endfunction

  function automatic int unsigned pick_value(int unsigned lo, int unsigned hi);
    case ($urandom_range(0, 3))
      0: return lo;
      1: return hi;
      2: return $urandom_range(lo, (hi - lo > 7) ? lo + 7 : hi);
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  function automatic reg_set_t random_regs();
    reg_set_t v;
    v[int'(REG_VALUE_OFFSET)]     = CFG_DATA_W'(pick_value(0, 1023));
    v[int'(REG_GATE_OFFSET)]      = CFG_DATA_W'(pick_value(0, 1023));
    v[int'(REG_ROW_TILE_OFFSET)]  = CFG_DATA_W'(pick_value(0, 1023));
    v[int'(REG_COL_TILES)]        = CFG_DATA_W'(pick_value(1, 1024));
    v[int'(REG_LOGICAL_ROWS)]     = CFG_DATA_W'(pick_value(0, 32768));
    v[int'(REG_SLICE_CHAN_TILES)] = CFG_DATA_W'(pick_value(1, 256));
    v[int'(REG_WIDE_CHAN_TILES)]  = CFG_DATA_W'(pick_value(1, 1024));
    // Now and then one register gets a raw value, zero and oversize included.
    if ($urandom_range(0, 3) == 0) v[$urandom_range(0, NUM_REGS - 1)] = CFG_DATA_W'($urandom);
    return v;
  endfunction

  // Send one request and hand it to the scoreboard on its transfer.
  task automatic send_group(input group_req_t req);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid             <= 1'b1;
    in_if.start_req         <= req.start_req;
    in_if.first_group_index <= req.first_group_index;
    in_if.walk_stride       <= req.walk_stride;
    in_if.wrap_high         <= req.wrap_high;
    in_if.wrap_low          <= req.wrap_low;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_group(req);
    groups_sent++;
  endtask

  // A start request followed by continued groups of the same walk.
  task automatic run_walk(input logic [GRP_W-1:0] first_grp, input logic [GRP_W-1:0] stride,
                          input logic [GRP_W-1:0] wrap_hi, input logic [GRP_W-1:0] wrap_lo,
                          input int len);
    group_req_t req;
    req.start_req         = 1'b1;
    req.first_group_index = first_grp;
    req.walk_stride       = stride;
    req.wrap_high         = wrap_hi;
    req.wrap_low          = wrap_lo;
    send_group(req);
    repeat (len - 1) send_group(follow_on_req());
  endtask

  // Drop the request and wait until every expected pair has come back.
  task automatic finish_phase();
    in_if.valid <= 1'b0;
    while (sb.expected_pairs.size() != 0) @(posedge clk);
  endtask

  // Write all registers in index order while the block is idle.
  task automatic apply_regs(input reg_set_t v);
    cfg_reg_e idx;
    idx = idx.first();
    do begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= idx;
      cfg_if.data  <= v[int'(idx)];
      @(posedge clk);
      while (!cfg_if.ready) @(posedge clk);
      sb.write_reg(idx, v[int'(idx)]);
      idx = idx.next();
    end while (idx != idx.first());
    cfg_if.valid <= 1'b0;
    phases++;
  endtask

  // Random settings, then mostly well-formed walks with some noise.
  task automatic random_phase();
    int               start_count;
    int               len;
    logic [GRP_W-1:0] first_grp, stride, wrap_hi, wrap_lo;
    group_req_t       req;
    apply_regs(random_regs());
    steady      = ($urandom_range(0, 3) == 0);
    start_count = groups_sent;
    while (groups_sent - start_count < PHASE_ITEMS && groups_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0: send_group(follow_on_req());
        1: begin
          req           = follow_on_req();
          req.start_req = 1'b1;
          send_group(req);
        end
        default: begin
          first_grp = sb.pick_group();
          len       = $urandom_range(1, 8);
          case ($urandom_range(0, 3))
            0: stride = GRP_W'($urandom_range(0, 3));
            1: stride = GRP_W'(sb.groups_per_row_tile());
            default: stride = GRP_W'($urandom);
          endcase
          wrap_hi = $urandom_range(0, 1) ? GRP_W'(first_grp + stride * $urandom_range(1, len))
                                         : GRP_W'($urandom);
          wrap_lo = $urandom_range(0, 1) ? sb.pick_group() : GRP_W'($urandom);
          run_walk(first_grp, stride, wrap_hi, wrap_lo, len);
        end
      endcase
    end
    finish_phase();
  endtask

  // Result side: random stalls, every transfer checked.
  initial begin
    page_pair_t got;
    int         stall;
    out_if.ready = 1'b0;
    wait (rst_n);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (!out_if.valid) @(posedge clk);
      got.value_page  = out_if.value_page;
      got.gate_page   = out_if.gate_page;
      got.row_in_tile = out_if.row_in_tile;
      got.is_padding  = out_if.is_padding;
      got.last        = out_if.last;
      sb.check_pair(got);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_gated_tile_page_address_generator_core: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Main sequence.
  initial begin
    in_if.valid             = 1'b0;
    in_if.start_req         = 1'b0;
    in_if.first_group_index = '0;
    in_if.walk_stride       = '0;
    in_if.wrap_high         = '0;
    in_if.wrap_low          = '0;
    cfg_if.valid            = 1'b0;
    cfg_if.index            = REG_VALUE_OFFSET;
    cfg_if.data             = '0;
    groups_sent             = 0;
    phases                  = 1;
    steady                  = 1'b0;
    sb                      = new();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset registers: a walk with no start uses the cleared walk, then the
    // index wraps at the top of its range and a zero stride wraps at once.
    send_group(follow_on_req());
    run_walk('1, '1, 24'hFFFFFE, '0, 3);
    run_walk('0, '0, '0, '0, 2);
    finish_phase();

    // All registers at the upper bounds of their random ranges.
    apply_regs('{16'd1023, 16'd1023, 16'd1023, 16'd1024, 16'd32768, 16'd256, 16'd1024});
    run_walk(24'hFFFFFF, 24'd1, 24'd0, 24'd5, 3);
    finish_phase();

    // All registers at the lower bounds of their random ranges, without any stalls.
    apply_regs('{16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'd1, 16'd1});
    steady = 1'b1;
    run_walk('0, 24'd1, '1, '0, 3);
    finish_phase();
    steady = 1'b0;

    // Zero column tiles and zero slice tiles fall back to a divisor of one.
    apply_regs('{16'd5, 16'd700, 16'd0, 16'd0, 16'd100, 16'd0, 16'd0});
    run_walk(24'd2, 24'd1, '1, '0, 3);
    finish_phase();

    // Oversize writes keep only the register width.
    apply_regs('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    run_walk(24'h000400, 24'h0007FF, '1, '0, 3);
    finish_phase();

    // Short tail: one row tile partly valid, the next fully padded.
    apply_regs('{16'd3, 16'd9, 16'd1, 16'd3, 16'd45, 16'd2, 16'd4});
    run_walk(24'd1, 24'd6, '1, '0, 4);
    finish_phase();

    while (groups_sent < ITEM_TARGET) random_phase();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d work groups across %0d register settings.", groups_sent, phases);
    $display("Checked %0d page pairs, %0d field mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("tb_gated_tile_page_address_generator_core: PASS");
    end else begin
      $display("tb_gated_tile_page_address_generator_core: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
design/gtpag_pkg.sv
design/gtpag_in_if.sv
design/gtpag_out_if.sv
design/gtpag_cfg_if.sv
design/gtpag_cfg_regs.sv
design/gtpag_div.sv
design/gated_tile_page_address_generator_core.sv
tb/tb_gated_tile_page_address_generator_core.sv
